/* rtl/core/yaz0_stream_decompressor_core_assert.svh */
// assertion macros used by the decompressor datapath
`ifndef YAZ0_STREAM_DECOMPRESSOR_CORE_ASSERT_SVH
`define YAZ0_STREAM_DECOMPRESSOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on i_clk, off during reset
`define YZD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("yzd assertion failed");
// next-cycle implication, clocked on i_clk, off during reset
`define YZD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("yzd assertion failed");
`else
`define YZD_ASSERT(label, ante, cons)
`define YZD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/yzd_pkg.sv */
// types, constants and helpers of the yaz0 stream decompressor
package yzd_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int OUT_LANES  = 8;
    localparam int LANE_AW    = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
    localparam int CNT_W      = 4;
    localparam int CFG_W      = 24;
    localparam int REM_W      = 9;

    localparam logic [CFG_W-1:0] MAX_RESET   = 24'hFFFFFF;
    localparam logic [7:0]       FLAG_LIT    = 8'h80;
    localparam logic [7:0]       LEN3_BIAS   = 8'h12;
    localparam logic [3:0]       HDR_LAST    = 4'h0F;
    localparam logic [3:0]       HDR_LEN_LO  = 4'd4;
    localparam logic [3:0]       HDR_LEN_HI  = 4'd8;
    localparam logic [3:0]       CODE_FLAGS  = 4'd8;
    localparam logic [CNT_W-1:0] LANES_FULL  = CNT_W'(OUT_LANES);

    // apb register offsets
    localparam logic REG_SKIP = 1'b0;
    localparam logic REG_MAX  = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_TOKEN,
        PH_REF1,
        PH_REF2,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd;
        logic put;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lit_start;
        logic copy_start;
        logic need_slot;
        logic slot_free;
        logic copy_more;
        logic has_emit;
    } t_stat;

    // magic word "Yaz0", one byte per header position
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = "Y";
            2'd1:    v = "a";
            2'd2:    v = "z";
            default: v = "0";
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/yzd_in_if.sv */
// input byte channel
interface yzd_in_if;
    import yzd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first;

    modport source (output valid, output in_byte, output first, input ready);
    modport sink   (input valid, input in_byte, input first, output ready);
endinterface

/* rtl/core/yzd_out_if.sv */
// result channel
interface yzd_out_if;
    import yzd_pkg::*;
    logic                valid;
    logic                ready;
    logic [63:0]         out_data;
    logic [CNT_W-1:0]    out_count;
    logic                last;
    logic                done_res;
    logic                bad_magic;
    logic [CFG_W-1:0]    total;

    modport source (output valid, output out_data, output out_count, output last,
                    output done_res, output bad_magic, output total, input ready);
    modport sink   (input valid, input out_data, input out_count, input last,
                    input done_res, input bad_magic, input total, output ready);
endinterface

/* rtl/core/yaz0_stream_decompressor_core.sv */
// top level of the yaz0 stream decompressor
//
// channel   dir   payload                                         handshake
// i_in      in    in_byte[7:0], first                             valid/ready
// o_out     out   out_data[63:0], out_count[3:0], last,           valid/ready
//                 done_res, bad_magic, total[23:0]
// apb       in    paddr[2:0], pwdata[31:0] -> prdata[31:0]        psel/penable, pready=1
//
// a header or code byte is accepted, then passes the emit state; a literal also passes the write state
// each byte of a back-reference is a history ram read then a write,
// the ram's registered read port sets this
// every 8 output bytes add a transfer that stalls if the result register is full
// reset is synchronous, active low; the history ram has no clear pass
module yaz0_stream_decompressor_core import yzd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    yzd_in_if.sink      i_in,
    yzd_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [CFG_W-1:0] cfg_skip;
    logic [CFG_W-1:0] cfg_max;
    t_cmd             cmd;
    t_stat            st;

    // configuration registers
    yzd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_skip  (cfg_skip),
        .o_max   (cfg_max)
    );

    // sequencer
    yzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // datapath
    yzd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_byte      (i_in.in_byte),
        .i_first     (i_in.first),
        .i_skip      (cfg_skip),
        .i_max       (cfg_max),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.out_data),
        .o_out_count (o_out.out_count),
        .o_last      (o_out.last),
        .o_done_res  (o_out.done_res),
        .o_bad_magic (o_out.bad_magic),
        .o_total     (o_out.total)
    );
endmodule

/* rtl/core/yzd_ram.sv */
// generic single-write, single-read ram with registered read
module yzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/yzd_regs.sv */
// apb configuration registers skip_bytes and max_out
module yzd_regs import yzd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CFG_W-1:0] o_skip,
    output logic [CFG_W-1:0] o_max
);
    logic [CFG_W-1:0] r_skip, n_skip;
    logic [CFG_W-1:0] r_max, n_max;
    logic             wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write decode
    always_comb begin
        n_skip = r_skip;
        n_max  = r_max;
        if (wr_en && paddr[2] == REG_SKIP && paddr[1:0] == 2'd0) begin
            n_skip = pwdata[CFG_W-1:0];
        end
        if (wr_en && paddr[2] == REG_MAX && paddr[1:0] == 2'd0) begin
            n_max = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip <= '0;
            r_max  <= MAX_RESET;
        end else begin
            r_skip <= n_skip;
            r_max  <= n_max;
        end
    end

    // read back
    assign prdata = (paddr[2] == REG_MAX) ? {8'd0, r_max} : {8'd0, r_skip};
    assign o_skip = r_skip;
    assign o_max  = r_max;
endmodule

/* rtl/core/yzd_datapath.sv */
// parser registers, history ring, counters, lane packer and result register
`include "yaz0_stream_decompressor_core_assert.svh"
module yzd_datapath import yzd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_st,
    input  logic [7:0]       i_byte,
    input  logic             i_first,
    input  logic [CFG_W-1:0] i_skip,
    input  logic [CFG_W-1:0] i_max,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [63:0]      o_out_data,
    output logic [CNT_W-1:0] o_out_count,
    output logic             o_last,
    output logic             o_done_res,
    output logic             o_bad_magic,
    output logic [CFG_W-1:0] o_total
);
    // parse and file state
    t_phase             r_phase, n_phase;
    logic [3:0]         r_hidx, n_hidx;
    logic [31:0]        r_len, n_len;
    logic [7:0]         r_code, n_code;
    logic [3:0]         r_bits, n_bits;
    logic [15:0]        r_tok, n_tok;
    logic [CFG_W-1:0]   r_decoded, n_decoded;
    logic [CFG_W-1:0]   r_written, n_written;
    logic               r_finished, n_finished;
    logic               r_magic_bad, n_magic_bad;
    logic [CFG_W-1:0]   r_skip, n_skip;
    logic [CFG_W-1:0]   r_limit, n_limit;
    logic [HIST_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic               r_was_fin, n_was_fin;
    // token in flight
    logic               r_is_lit, n_is_lit;
    logic [7:0]         r_lit, n_lit;
    logic [HIST_AW-1:0] r_src, n_src;
    logic [REM_W-1:0]   r_remain, n_remain;
    // lane packer
    logic [7:0]         r_pack [OUT_LANES];
    logic [7:0]         n_pack [OUT_LANES];
    logic [CNT_W-1:0]   r_pack_cnt, n_pack_cnt;
    // result register
    logic               r_ovalid, n_ovalid;
    logic [63:0]        r_odata, n_odata;
    logic [CNT_W-1:0]   r_ocnt, n_ocnt;
    logic               r_olast, n_olast;
    logic               r_odone, n_odone;
    logic               r_obad, n_obad;
    logic [CFG_W-1:0]   r_ototal, n_ototal;

    // view of the state as the accepted byte sees it, after a new-file start
    t_phase             e_phase;
    logic [3:0]         e_hidx;
    logic [31:0]        e_len;
    logic [7:0]         e_code;
    logic [15:0]        e_tok;
    logic [HIST_AW-1:0] e_wr_ptr;
    logic               e_finished;

    logic [7:0]         ram_rdata;
    logic [7:0]         wbyte;
    logic               outbound;
    logic [CFG_W-1:0]   w_inc;
    logic               fin_now;
    logic               ended;
    logic               slot_free;
    logic [63:0]        pack_flat;
    logic [31:0]        lim_diff;
    logic [CFG_W-1:0]   lim_val;
    logic [3:0]         nb;
    logic [HIST_AW-1:0] ref_dist;

    assign e_phase    = i_first ? PH_HEADER : r_phase;
    assign e_hidx     = i_first ? 4'd0 : r_hidx;
    assign e_len      = i_first ? 32'd0 : r_len;
    assign e_code     = i_first ? 8'd0 : r_code;
    assign e_tok      = i_first ? 16'd0 : r_tok;
    assign e_wr_ptr   = i_first ? '0 : r_wr_ptr;
    assign e_finished = i_first ? 1'b0 : r_finished;

    // decoded byte and its bookkeeping
    assign wbyte     = r_is_lit ? r_lit : ram_rdata;
    assign outbound  = r_decoded >= r_skip;
    assign w_inc     = r_written + CFG_W'(1);
    assign fin_now   = outbound && (w_inc >= r_limit);
    assign ended     = r_finished && !r_was_fin;
    assign slot_free = !r_ovalid || i_out_ready;

    // limit at the end of the header
    assign lim_diff = (e_len > {8'd0, i_skip}) ? (e_len - {8'd0, i_skip}) : 32'd0;
    assign lim_val  = (lim_diff > {8'd0, i_max}) ? i_max : lim_diff[CFG_W-1:0];

    always_comb begin
        pack_flat = '0;
        for (int i = 0; i < OUT_LANES; i++) begin
            pack_flat[8*i +: 8] = r_pack[i];
        end
    end

    // status to the controller
    always_comb begin
        o_st.lit_start  = (e_phase == PH_TOKEN) && ((e_code & FLAG_LIT) != 8'd0);
        o_st.copy_start = ((e_phase == PH_REF1) && (e_tok[15:12] != 4'd0))
                          || (e_phase == PH_REF2);
        o_st.need_slot  = outbound && (r_pack_cnt == LANES_FULL);
        o_st.slot_free  = slot_free;
        o_st.copy_more  = !r_is_lit && (r_remain > REM_W'(1)) && !fin_now;
        o_st.has_emit   = (r_pack_cnt != '0) || ended;
    end

    // next-state logic
    always_comb begin
        n_phase     = r_phase;
        n_hidx      = r_hidx;
        n_len       = r_len;
        n_code      = r_code;
        n_bits      = r_bits;
        n_tok       = r_tok;
        n_decoded   = r_decoded;
        n_written   = r_written;
        n_finished  = r_finished;
        n_magic_bad = r_magic_bad;
        n_skip      = r_skip;
        n_limit     = r_limit;
        n_wr_ptr    = r_wr_ptr;
        n_was_fin   = r_was_fin;
        n_is_lit    = r_is_lit;
        n_lit       = r_lit;
        n_src       = r_src;
        n_remain    = r_remain;
        n_pack      = r_pack;
        n_pack_cnt  = r_pack_cnt;
        n_ovalid    = r_ovalid && !i_out_ready;
        n_odata     = r_odata;
        n_ocnt      = r_ocnt;
        n_olast     = r_olast;
        n_odone     = r_odone;
        n_obad      = r_obad;
        n_ototal    = r_ototal;
        nb          = '0;
        ref_dist    = '0;

        // accepted byte: parse step
        if (i_cmd.accept) begin
            if (i_first) begin
                n_phase     = PH_HEADER;
                n_hidx      = '0;
                n_len       = '0;
                n_code      = '0;
                n_bits      = '0;
                n_tok       = '0;
                n_decoded   = '0;
                n_written   = '0;
                n_finished  = 1'b0;
                n_magic_bad = 1'b0;
                n_skip      = '0;
                n_limit     = '0;
                n_wr_ptr    = '0;
            end
            n_was_fin = e_finished;
            n_lit     = i_byte;
            case (e_phase)
                PH_HEADER: begin
                    if (e_hidx < HDR_LEN_LO && i_byte != magic_byte(e_hidx[1:0])) begin
                        n_magic_bad = 1'b1;
                        n_finished  = 1'b1;
                        n_phase     = PH_DONE;
                    end else begin
                        if (e_hidx >= HDR_LEN_LO && e_hidx < HDR_LEN_HI) begin
                            n_len = {e_len[23:0], i_byte};
                        end
                        if (e_hidx >= HDR_LAST) begin
                            n_skip  = i_skip;
                            n_limit = lim_val;
                            if (lim_val == '0) begin
                                n_finished = 1'b1;
                                n_phase    = PH_DONE;
                            end else begin
                                n_phase = PH_CODE;
                            end
                        end else begin
                            n_hidx = e_hidx + 4'd1;
                        end
                    end
                end
                PH_CODE: begin
                    n_code  = i_byte;
                    n_bits  = CODE_FLAGS;
                    n_phase = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if ((e_code & FLAG_LIT) != 8'd0) begin
                        n_is_lit = 1'b1;
                        n_remain = REM_W'(1);
                    end else begin
                        n_tok   = {i_byte, 8'd0};
                        n_phase = PH_REF1;
                    end
                end
                PH_REF1: begin
                    n_tok = {e_tok[15:8], i_byte};
                    if (e_tok[15:12] == 4'd0) begin
                        n_phase = PH_REF2;
                    end else begin
                        ref_dist = {e_tok[11:8], i_byte};
                        n_is_lit = 1'b0;
                        n_src    = e_wr_ptr - ref_dist - HIST_AW'(1);
                        n_remain = REM_W'(e_tok[15:12]) + REM_W'(2);
                    end
                end
                PH_REF2: begin
                    ref_dist = e_tok[11:0];
                    n_is_lit = 1'b0;
                    n_src    = e_wr_ptr - ref_dist - HIST_AW'(1);
                    n_remain = REM_W'(i_byte) + REM_W'(LEN3_BIAS);
                end
                default: begin
                end
            endcase
        end

        // one decoded byte into history and packer
        if (i_cmd.put) begin
            n_wr_ptr = r_wr_ptr + HIST_AW'(1);
            n_src    = r_src + HIST_AW'(1);
            n_remain = r_remain - REM_W'(1);
            if (outbound) begin
                if (r_pack_cnt == LANES_FULL) begin
                    n_ovalid = 1'b1;
                    n_odata  = pack_flat;
                    n_ocnt   = r_pack_cnt;
                    n_olast  = 1'b0;
                    n_odone  = 1'b0;
                    n_obad   = r_magic_bad;
                    n_ototal = r_written;
                    for (int i = 0; i < OUT_LANES; i++) begin
                        n_pack[i] = 8'd0;
                    end
                    n_pack[0]  = wbyte;
                    n_pack_cnt = CNT_W'(1);
                end else begin
                    n_pack[r_pack_cnt[LANE_AW-1:0]] = wbyte;
                    n_pack_cnt = r_pack_cnt + CNT_W'(1);
                end
                n_written = w_inc;
                if (fin_now) begin
                    n_finished = 1'b1;
                    n_phase    = PH_DONE;
                end
            end
            if (r_decoded != MAX_RESET) begin
                n_decoded = r_decoded + CFG_W'(1);
            end
            // token complete: step to the next flag
            if (!fin_now && (r_is_lit || r_remain == REM_W'(1))) begin
                n_code  = {r_code[6:0], 1'b0};
                nb      = (r_bits != 4'd0) ? (r_bits - 4'd1) : 4'd0;
                n_bits  = nb;
                n_phase = (nb == 4'd0) ? PH_CODE : PH_TOKEN;
            end
        end

        // final result of this input byte
        if (i_cmd.emit) begin
            n_ovalid = 1'b1;
            n_odata  = pack_flat;
            n_ocnt   = r_pack_cnt;
            n_olast  = 1'b1;
            n_odone  = ended;
            n_obad   = r_magic_bad;
            n_ototal = r_written;
            for (int i = 0; i < OUT_LANES; i++) begin
                n_pack[i] = 8'd0;
            end
            n_pack_cnt = '0;
            n_was_fin  = r_finished;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hidx      <= '0;
            r_len       <= '0;
            r_code      <= '0;
            r_bits      <= '0;
            r_tok       <= '0;
            r_decoded   <= '0;
            r_written   <= '0;
            r_finished  <= 1'b0;
            r_magic_bad <= 1'b0;
            r_skip      <= '0;
            r_limit     <= '0;
            r_wr_ptr    <= '0;
            r_was_fin   <= 1'b0;
            r_pack_cnt  <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < OUT_LANES; i++) begin
                r_pack[i] <= 8'd0;
            end
        end else begin
            r_phase     <= n_phase;
            r_hidx      <= n_hidx;
            r_len       <= n_len;
            r_code      <= n_code;
            r_bits      <= n_bits;
            r_tok       <= n_tok;
            r_decoded   <= n_decoded;
            r_written   <= n_written;
            r_finished  <= n_finished;
            r_magic_bad <= n_magic_bad;
            r_skip      <= n_skip;
            r_limit     <= n_limit;
            r_wr_ptr    <= n_wr_ptr;
            r_was_fin   <= n_was_fin;
            r_pack_cnt  <= n_pack_cnt;
            r_ovalid    <= n_ovalid;
            r_pack      <= n_pack;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_is_lit <= n_is_lit;
        r_lit    <= n_lit;
        r_src    <= n_src;
        r_remain <= n_remain;
        r_odata  <= n_odata;
        r_ocnt   <= n_ocnt;
        r_olast  <= n_olast;
        r_odone  <= n_odone;
        r_obad   <= n_obad;
        r_ototal <= n_ototal;
    end

    // history ring
    yzd_ram #(
        .WIDTH(8),
        .DEPTH(HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.put),
        .i_waddr (r_wr_ptr),
        .i_wdata (wbyte),
        .i_re    (i_cmd.rd),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;
    assign o_out_count = r_ocnt;
    assign o_last      = r_olast;
    assign o_done_res  = r_odone;
    assign o_bad_magic = r_obad;
    assign o_total     = r_ototal;

    // checks
    `YZD_ASSERT(a_pack_bound, 1'b1, r_pack_cnt <= LANES_FULL)
    `YZD_ASSERT(a_fin_phase, r_finished, r_phase == PH_DONE)
    `YZD_ASSERT(a_under_limit, r_phase != PH_HEADER && r_phase != PH_DONE, r_written < r_limit)
    `YZD_ASSERT_NEXT(a_emit_loads, i_cmd.emit, r_ovalid && r_olast && r_pack_cnt == '0)
endmodule

/* rtl/core/yzd_ctrl.sv */
// sequencer: input transfer, history read, byte write, result emit
module yzd_ctrl import yzd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_st,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.lit_start) begin
                        n_state = ST_WR;
                    end else if (i_st.copy_start) begin
                        n_state = ST_RD;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_WR;
            end
            ST_WR: begin
                if (!(i_st.need_slot && !i_st.slot_free)) begin
                    o_cmd.put = 1'b1;
                    n_state   = i_st.copy_more ? ST_RD : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_st.has_emit) begin
                    n_state = ST_IDLE;
                end else if (i_st.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

/* test/yaz0_stream_decompressor_core_test.sv */
// self-checking testbench of the yaz0 stream decompressor core
`timescale 1ns / 1ps

module yaz0_stream_decompressor_core_test;
    import yzd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYC  = 700;
    localparam int COPY_MAX    = 273;
    localparam logic [31:0] MAGIC = "Yaz0";

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        done;
        logic        bad;
        logic [23:0] total;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       f;
        logic       typed;
        out_beat_t  e;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    yzd_in_if  in_ch ();
    yzd_out_if out_ch ();

    yaz0_stream_decompressor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // decoder mirror state
    logic [7:0]  ring [4096];
    bit          ring_ok [4096];
    int          ring_ok_cnt;
    logic [11:0] wptr;
    t_phase      phase;
    logic [3:0]  hdr_idx;
    logic [31:0] len_field;
    logic [7:0]  code;
    logic [3:0]  flags_left;
    logic [15:0] tok;
    logic [23:0] dec_cnt;
    logic [23:0] wr_cnt;
    bit          fin;
    bit          magic_err;
    logic [23:0] skip_held;
    logic [23:0] lim_held;
    logic [23:0] cfg_skip;
    logic [23:0] cfg_max;
    logic [7:0]  got [COPY_MAX];
    int          got_n;

    out_beat_t   beats_due[$];
    logic [7:0]  token_tail[$];
    int          errors = 0;
    int          sent = 0;
    int          burst_left = 0;

    function automatic void new_file();
        wptr = '0; phase = PH_HEADER; hdr_idx = '0; len_field = '0;
        code = '0; flags_left = '0; tok = '0; dec_cnt = '0; wr_cnt = '0;
        fin = 0; magic_err = 0; skip_held = '0; lim_held = '0;
    endfunction

    function automatic void emit_byte(input logic [7:0] v);
        ring[wptr] = v;
        if (!ring_ok[wptr]) begin
            ring_ok[wptr] = 1;
            ring_ok_cnt++;
        end
        wptr++;
        if (dec_cnt >= skip_held) begin
            if (got_n < COPY_MAX) begin
                got[got_n] = v;
                got_n++;
            end
            wr_cnt++;
            if (wr_cnt >= lim_held) begin
                fin = 1;
                phase = PH_DONE;
            end
        end
        if (dec_cnt != 24'hFFFFFF) dec_cnt++;
    endfunction

    function automatic void copy_back(input logic [11:0] ref_dist, input int len);
        logic [11:0] src;
        src = wptr - ref_dist - 12'd1;
        for (int i = 0; i < len && !fin; i++) begin
            emit_byte(ring[src]);
            src++;
        end
    endfunction

    function automatic void advance_flag();
        if (fin) return;
        code = code << 1;
        if (flags_left > 0) flags_left--;
        phase = (flags_left == 0) ? PH_CODE : PH_TOKEN;
    endfunction

    // advance the mirror by one accepted byte and queue its results
    function automatic void decode_byte(input logic [7:0] b, input logic f,
                                        input bit queue_it);
        bit          was_fin;
        bit          ended;
        logic [23:0] wr_before;
        longint      lim;
        int          chunks, base, cnt;
        out_beat_t   r;
        if (f) new_file();
        was_fin   = fin;
        wr_before = wr_cnt;
        got_n     = 0;
        case (phase)
            PH_HEADER: begin
                if (hdr_idx < 4 && b != MAGIC[31 - 8*hdr_idx -: 8]) begin
                    magic_err = 1;
                    fin = 1;
                    phase = PH_DONE;
                end else begin
                    if (hdr_idx >= 4 && hdr_idx < 8) len_field = {len_field[23:0], b};
                    if (hdr_idx == 4'hF) begin
                        skip_held = cfg_skip;
                        lim = (len_field > skip_held) ? longint'(len_field) - skip_held : 0;
                        if (lim > cfg_max) lim = cfg_max;
                        lim_held = lim[23:0];
                        if (lim_held == 0) begin
                            fin = 1;
                            phase = PH_DONE;
                        end else begin
                            phase = PH_CODE;
                        end
                    end else begin
                        hdr_idx++;
                    end
                end
            end
            PH_CODE: begin
                code = b;
                flags_left = 4'd8;
                phase = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (code[7]) begin
                    emit_byte(b);
                    advance_flag();
                end else begin
                    tok = {b, 8'h00};
                    phase = PH_REF1;
                end
            end
            PH_REF1: begin
                tok[7:0] = b;
                if (tok[15:12] == 0) begin
                    phase = PH_REF2;
                end else begin
                    copy_back(tok[11:0], int'(tok[15:12]) + 2);
                    advance_flag();
                end
            end
            PH_REF2: begin
                copy_back(tok[11:0], int'(b) + 18);
                advance_flag();
            end
            default: ;
        endcase

        ended = fin && !was_fin;
        if (!queue_it || (got_n == 0 && !ended)) return;
        chunks = (got_n == 0) ? 1 : (got_n + 7) / 8;
        for (int k = 0; k < chunks; k++) begin
            base = k * 8;
            cnt  = (got_n > base) ? got_n - base : 0;
            if (cnt > 8) cnt = 8;
            r = '0;
            for (int j = 0; j < cnt; j++) r.data[8*j +: 8] = got[base + j];
            r.cnt   = 4'(cnt);
            r.last  = (k + 1 == chunks);
            r.done  = (k + 1 == chunks) && ended;
            r.bad   = magic_err;
            r.total = wr_before + 24'(base + cnt);
            beats_due.push_back(r);
        end
    endfunction

    // a back-reference may only read entries written since reset
    function automatic bit ref_readable(input logic [11:0] ref_dist, input int len);
        logic [11:0] src;
        src = wptr - ref_dist - 12'd1;
        for (int k = 0; k < len; k++) begin
            if (!ring_ok[12'(src + k)] && k < int'(ref_dist) + 1) return 0;
        end
        return 1;
    endfunction

    // next body byte, shaped by where the mirror stands in the stream
    function automatic logic [7:0] next_body_byte();
        logic [7:0]  c;
        logic [3:0]  nib;
        logic [7:0]  ext;
        logic [11:0] d;
        int          len;
        if (token_tail.size() > 0) return token_tail.pop_front();
        if (phase == PH_CODE) begin
            c = 8'($urandom);
            // the first flag may be a reference only if distance 0 is readable
            if (!ring_ok[wptr - 12'd1]) c[7] = 1'b1;
            return c;
        end
        if (phase != PH_TOKEN || code[7]) return 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            nib = 4'h0;
            ext = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
            len = int'(ext) + 18;
        end else begin
            nib = 4'($urandom_range(1, 15));
            ext = '0;
            len = int'(nib) + 2;
        end
        d = 12'($urandom_range(0, 15));
        for (int t = 0; t < 16; t++) begin
            d = $urandom_range(0, 1) ? 12'($urandom_range(0, 15)) : 12'($urandom);
            if (ref_readable(d, len)) break;
            d = '0;
        end
        token_tail.push_back(d[7:0]);
        if (nib == 0) token_tail.push_back(ext);
        return {nib, d[11:8]};
    endfunction

    // one input transfer with burst and gap pacing
    task automatic put_item(input logic [7:0] b, input logic f,
                            input bit typed, input out_beat_t e);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.first   = f;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_byte(b, f, !typed);
        if (typed) beats_due.push_back(e);
        burst_left--;
        sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        burst_left = 0;
    endtask

    // sender holds off until every result is back and the core is quiet
    task automatic drain();
        idle_input();
        while (beats_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [23:0] v);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = {8'h00, v};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (idx == REG_SKIP) cfg_skip = v;
        else cfg_max = v;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic send_file(input int budget);
        logic [31:0] len;
        logic [7:0]  b;
        int          bad_at;
        int          n;
        bad_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : -1;
        len = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 120));
        for (int i = 0; i < 16; i++) begin
            if (i < 4) begin
                b = MAGIC[31 - 8*i -: 8];
                if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
            end else if (i < 8) begin
                b = len[31 - 8*(i-4) -: 8];
            end else begin
                b = 8'($urandom);
            end
            put_item(b, i == 0, 0, '0);
            if (fin) break;
        end
        n = 0;
        while (!fin && n < budget) begin
            put_item(next_body_byte(), 1'b0, 0, '0);
            n++;
        end
        // bytes after the end of a file are ignored
        if (fin && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) put_item(8'($urandom), 1'b0, 0, '0);
        end
        token_tail.delete();
    endtask

    // directed stimulus: bad magic, then a tiny file stopped inside a reference
    dir_row_t dir_tab [22] = '{
        '{8'h58, 1'b1, 1'b1, '{64'h0, 4'd0, 1'b1, 1'b1, 1'b1, 24'd0}},
        '{8'h59, 1'b1, 1'b0, '0}, '{8'h61, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b0, 1'b0, '0}, '{8'h30, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h03, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hA5, 1'b0, 1'b0, '0}, '{8'h5A, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h10, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0}
    };

    // result stall pattern, its character picked by stall_cyc[8:7]
    int unsigned stall_cyc = 0;
    always @(negedge i_clk) begin
        stall_cyc++;
        case (stall_cyc[8:7])
            2'd0: out_ch.ready = 1'b1;
            2'd1: out_ch.ready = 1'($urandom_range(0, 1));
            2'd2: out_ch.ready = (stall_cyc[1:0] == 2'd0);
            default: out_ch.ready = ($urandom_range(0, 3) != 0);
        endcase
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        out_beat_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (beats_due.size() == 0) begin
                $error("unexpected result transfer: out_count %0d total %0d",
                       out_ch.out_count, out_ch.total);
                errors++;
            end else begin
                e = beats_due.pop_front();
                if (out_ch.out_data !== e.data) begin
                    $error("out_data: expected %h got %h", e.data, out_ch.out_data);
                    errors++;
                end
                if (out_ch.out_count !== e.cnt) begin
                    $error("out_count: expected %0d got %0d", e.cnt, out_ch.out_count);
                    errors++;
                end
                if (out_ch.last !== e.last) begin
                    $error("last: expected %0b got %0b", e.last, out_ch.last);
                    errors++;
                end
                if (out_ch.done_res !== e.done) begin
                    $error("done_res: expected %0b got %0b", e.done, out_ch.done_res);
                    errors++;
                end
                if (out_ch.bad_magic !== e.bad) begin
                    $error("bad_magic: expected %0b got %0b", e.bad, out_ch.bad_magic);
                    errors++;
                end
                if (out_ch.total !== e.total) begin
                    $error("total: expected %0d got %0d", e.total, out_ch.total);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer and no register access
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (in_ch.valid && in_ch.ready)
            || (out_ch.valid && out_ch.ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    logic [23:0] skip_set [6] = '{24'd0, 24'd3, 24'hFFFFFF, 24'd0, 24'd10, 24'd1};
    logic [23:0] max_set  [6] = '{24'hFFFFFF, 24'd20, 24'hFFFFFF, 24'd0, 24'd5, 24'hFFFFFF};

    initial begin
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.first = 1'b0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 4096; i++) ring_ok[i] = 0;
        ring_ok_cnt = 0;
        cfg_skip = '0;
        cfg_max = MAX_RESET;
        new_file();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        reg_write(REG_SKIP, 24'd0);
        reg_write(REG_MAX, 24'd3);
        foreach (dir_tab[i]) put_item(dir_tab[i].b, dir_tab[i].f, dir_tab[i].typed, dir_tab[i].e);
        drain();

        // random files under each register setting
        for (int p = 0; p < 6; p++) begin
            reg_write(REG_SKIP, skip_set[p]);
            reg_write(REG_MAX, max_set[p]);
            sent = 0;
            while (sent < 45) send_file($urandom_range(4, 60));
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
